### design/stfm_pkg.sv
`default_nettype none
package stfm_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_ITERS = 24;

    // angle scaling to q2.30 and reduction widths
    localparam int SHIFT   = 30 - FRAC_BITS;
    localparam int ZW      = 34 + SHIFT;
    localparam int RED_TOP = SHIFT - 2;
    localparam int RKW     = $clog2(RED_TOP + 1);
    localparam int CW      = 34;

    localparam logic signed [31:0] FX_ONE = 32'(64'sd1 <<< FRAC_BITS);

    localparam logic signed [ZW-1:0] Q30_PI      = ZW'(64'sd3373259426);
    localparam logic signed [ZW-1:0] Q30_TWO_PI  = ZW'(64'sd6746518852);
    localparam logic signed [ZW-1:0] Q30_HALF_PI = ZW'(64'sd1686629713);
    localparam logic signed [CW-1:0] Q30_INV_GAIN = CW'(64'sd652032874);

    localparam logic [2:0] FUNC_ROT   = 3'd0;
    localparam logic [2:0] FUNC_CTR   = 3'd1;
    localparam logic [2:0] FUNC_SOR   = 3'd2;
    localparam logic [2:0] FUNC_SCALE = 3'd3;
    localparam logic [2:0] FUNC_TRN   = 3'd4;

    // one queued input transaction after classification
    typedef struct packed {
        logic               store;
        logic [2:0]         func;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] ang;
        logic               go;
    } stfm_item_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        logic signed [CW-1:0] v;
        case (i)
            5'd0:    v = CW'(64'sd843314856);
            5'd1:    v = CW'(64'sd497837829);
            5'd2:    v = CW'(64'sd263043836);
            5'd3:    v = CW'(64'sd133525158);
            5'd4:    v = CW'(64'sd67021686);
            5'd5:    v = CW'(64'sd33543515);
            5'd6:    v = CW'(64'sd16775850);
            5'd7:    v = CW'(64'sd8388437);
            5'd8:    v = CW'(64'sd4194282);
            5'd9:    v = CW'(64'sd2097149);
            5'd10:   v = CW'(64'sd1048575);
            5'd11:   v = CW'(64'sd524287);
            5'd12:   v = CW'(64'sd262143);
            5'd13:   v = CW'(64'sd131071);
            5'd14:   v = CW'(64'sd65535);
            5'd15:   v = CW'(64'sd32767);
            5'd16:   v = CW'(64'sd16383);
            5'd17:   v = CW'(64'sd8191);
            5'd18:   v = CW'(64'sd4095);
            5'd19:   v = CW'(64'sd2047);
            5'd20:   v = CW'(64'sd1023);
            5'd21:   v = CW'(64'sd511);
            5'd22:   v = CW'(64'sd255);
            5'd23:   v = CW'(64'sd127);
            5'd24:   v = CW'(64'sd63);
            5'd25:   v = CW'(64'sd31);
            5'd26:   v = CW'(64'sd15);
            5'd27:   v = CW'(64'sd7);
            5'd28:   v = CW'(64'sd3);
            5'd29:   v = CW'(64'sd1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // product rounding half up and saturation to 32 bits
    function automatic logic signed [31:0] fx_rnd(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (s > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (s < -64'sd2147483648)
            return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] fx_sat33(input logic signed [32:0] s);
        if (s[32] != s[31])
            return s[32] ? 32'sh80000000 : 32'sh7fffffff;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return fx_sat33({a[31], a} + {b[31], b});
    endfunction

    function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return fx_sat33({a[31], a} - {b[31], b});
    endfunction

    // row-major index of a 3x3 element
    function automatic logic [3:0] mat_idx(input logic [1:0] i, input logic [1:0] j);
        return ({2'b00, i} << 1) + {2'b00, i} + {2'b00, j};
    endfunction

endpackage
`default_nettype wire

### design/stfm_front.sv
`default_nettype none
module stfm_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [2:0]           func,
    input  wire logic signed [31:0]   comp_x,
    input  wire logic signed [31:0]   comp_y,
    input  wire logic signed [31:0]   comp_z,
    input  wire logic signed [31:0]   angle,
    input  wire logic                 go,
    input  wire logic                 deq,
    output logic                      avail,
    output stfm_pkg::stfm_item_t      item
);
    import stfm_pkg::*;

    stfm_item_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       enq;
    stfm_item_t cls;

    assign full  = (cnt_reg == 2'd2);
    assign avail = (cnt_reg != 2'd0);
    assign item  = slot_reg[rd_ptr_reg];
    assign enq   = push && !full;

    // classify the incoming transaction
    always_comb
    begin
        cls.store = (func <= FUNC_TRN);
        cls.func  = func;
        cls.x     = comp_x;
        cls.y     = comp_y;
        cls.z     = comp_z;
        cls.ang   = angle;
        cls.go    = go;
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (enq)
            slot_reg[wr_ptr_reg] <= cls;
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (enq)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (deq)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, enq} - {1'b0, deq};
        end
    end

endmodule
`default_nettype wire

### design/stfm_cordic.sv
`default_nettype none
module stfm_cordic (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] ang,
    output logic                    done,
    output logic signed [31:0]      sin_val,
    output logic signed [31:0]      cos_val
);
    import stfm_pkg::*;

    typedef enum logic [2:0] {C_IDLE, C_RED, C_WRAP, C_FOLD, C_ITER, C_RND} cstate_t;

    cstate_t              state_reg;
    logic [RKW-1:0]       k_reg;
    logic [4:0]           i_reg;
    logic                 sgn_reg, neg_reg, done_reg;
    logic [ZW-1:0]        mag_reg;
    logic signed [ZW-1:0] zw_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [31:0]   sin_reg, cos_reg;

    logic [ZW-1:0]        step_val;
    logic signed [ZW-1:0] z_scaled, z_signed;
    logic signed [CW-1:0] xs, ys, at, xr, yr;

    assign done    = done_reg;
    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

    assign z_scaled = ZW'(ang) <<< SHIFT;
    assign step_val = ZW'(Q30_TWO_PI) << k_reg;
    assign z_signed = sgn_reg ? -$signed(mag_reg) : $signed(mag_reg);
    assign xs       = x_reg >>> i_reg;
    assign ys       = y_reg >>> i_reg;
    assign at       = atan_q30(i_reg);
    assign xr       = (x_reg + (CW'(1) <<< (SHIFT - 1))) >>> SHIFT;
    assign yr       = (y_reg + (CW'(1) <<< (SHIFT - 1))) >>> SHIFT;

    // sequencer: reduce modulo two pi, fold, iterate, round
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        k_reg     <= RKW'(RED_TOP);
                        state_reg <= C_RED;
                    end
                end
                C_RED:
                begin
                    if (k_reg == '0)
                        state_reg <= C_WRAP;
                    else
                        k_reg <= k_reg - 1'b1;
                end
                C_WRAP:
                    state_reg <= C_FOLD;
                C_FOLD:
                begin
                    i_reg     <= '0;
                    state_reg <= C_ITER;
                end
                C_ITER:
                begin
                    if (i_reg == 5'(CORDIC_ITERS - 1))
                        state_reg <= C_RND;
                    else
                        i_reg <= i_reg + 1'b1;
                end
                C_RND:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                    state_reg <= C_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                sgn_reg <= ang[31];
                mag_reg <= ang[31] ? unsigned'(-z_scaled) : unsigned'(z_scaled);
            end
            C_RED:
            begin
                if (mag_reg >= step_val)
                    mag_reg <= mag_reg - step_val;
            end
            C_WRAP:
            begin
                if (z_signed > Q30_PI)
                    zw_reg <= z_signed - Q30_TWO_PI;
                else if (z_signed < -Q30_PI)
                    zw_reg <= z_signed + Q30_TWO_PI;
                else
                    zw_reg <= z_signed;
            end
            C_FOLD:
            begin
                x_reg <= Q30_INV_GAIN;
                y_reg <= '0;
                if (zw_reg > Q30_HALF_PI)
                begin
                    z_reg   <= CW'(zw_reg - Q30_PI);
                    neg_reg <= 1'b1;
                end
                else if (zw_reg < -Q30_HALF_PI)
                begin
                    z_reg   <= CW'(zw_reg + Q30_PI);
                    neg_reg <= 1'b1;
                end
                else
                begin
                    z_reg   <= CW'(zw_reg);
                    neg_reg <= 1'b0;
                end
            end
            C_ITER:
            begin
                if (!z_reg[CW-1])
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
            end
            C_RND:
            begin
                cos_reg <= neg_reg ? 32'(-xr) : 32'(xr);
                sin_reg <= neg_reg ? 32'(-yr) : 32'(yr);
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

### design/stfm_back.sv
`default_nettype none
module stfm_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 avail,
    input  wire stfm_pkg::stfm_item_t item,
    output logic                      deq,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [1:0]                row,
    output logic signed [31:0]        col0,
    output logic signed [31:0]        col1,
    output logic signed [31:0]        col2,
    output logic signed [31:0]        col3,
    output logic                      last_row
);
    import stfm_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE, B_SC_START, B_SC_WAIT, B_ROD, B_ROD_OUT, B_MAT, B_HOLD
    } bstate_t;
    typedef enum logic [1:0] {M_SSR, M_RSR, M_MM, M_C2} mat_t;

    bstate_t state_reg;
    mat_t    mat_reg;
    logic    ph_reg, rsel_reg;
    logic [3:0] u_reg;
    logic [1:0] ci_reg, cj_reg, ck_reg, out_row_reg;

    // parameter store
    logic signed [31:0] rot_reg [3];
    logic signed [31:0] rot_a_reg;
    logic signed [31:0] ctr_reg [3];
    logic signed [31:0] sor_reg [3];
    logic signed [31:0] sor_a_reg;
    logic signed [31:0] scl_reg [3];
    logic signed [31:0] trn_reg [3];

    // work registers
    logic signed [63:0] prod_reg;
    logic signed [31:0] hold_reg, sth_reg, vth_reg, acc_reg;
    logic signed [31:0] tmp_reg [9];
    logic signed [31:0] r_reg [9];
    logic signed [31:0] sr_reg [9];
    logic signed [31:0] rsr_reg [9];
    logic signed [31:0] ssr_reg [9];
    logic signed [31:0] m_reg [9];
    logic signed [31:0] c3_reg [3];

    logic               sc_done;
    logic signed [31:0] sc_sin, sc_cos;
    logic signed [31:0] ax, ay, az, rod_a, rod_b, mat_a, mat_b, mul_a, mul_b;
    logic signed [31:0] res, acc_new, tc;
    logic signed [31:0] e [9];
    logic [1:0]         klast, jlast;
    logic               k_end, j_end, i_end, tmp_we;
    logic [3:0]         tmp_idx;

    stfm_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == B_SC_START),
        .ang     (rsel_reg ? sor_a_reg : rot_a_reg),
        .done    (sc_done),
        .sin_val (sc_sin),
        .cos_val (sc_cos)
    );

    assign deq      = (state_reg == B_IDLE) && avail;
    assign empty    = (state_reg != B_HOLD);
    assign row      = out_row_reg;
    assign col0     = m_reg[0];
    assign col1     = m_reg[1];
    assign col2     = m_reg[2];
    assign col3     = c3_reg[0];
    assign last_row = (out_row_reg == 2'd2);

    assign ax = rsel_reg ? sor_reg[0] : rot_reg[0];
    assign ay = rsel_reg ? sor_reg[1] : rot_reg[1];
    assign az = rsel_reg ? sor_reg[2] : rot_reg[2];

    // rodrigues product schedule: squares and cross terms times (1 - cos), then axis times sin
    always_comb
    begin
        case (u_reg)
            4'd0:    begin rod_a = ax;       rod_b = ax;      end
            4'd2:    begin rod_a = ay;       rod_b = ay;      end
            4'd4:    begin rod_a = az;       rod_b = az;      end
            4'd6:    begin rod_a = ax;       rod_b = ay;      end
            4'd8:    begin rod_a = ay;       rod_b = az;      end
            4'd10:   begin rod_a = az;       rod_b = ax;      end
            4'd12:   begin rod_a = ax;       rod_b = sth_reg; end
            4'd13:   begin rod_a = ay;       rod_b = sth_reg; end
            4'd14:   begin rod_a = az;       rod_b = sth_reg; end
            default: begin rod_a = hold_reg; rod_b = vth_reg; end
        endcase
        tmp_we  = (u_reg >= 4'd12) || u_reg[0];
        tmp_idx = (u_reg >= 4'd12) ? u_reg - 4'd6 : {1'b0, u_reg[3:1]};
    end

    // matrix product operands
    always_comb
    begin
        case (mat_reg)
            M_SSR:
            begin
                mat_a = scl_reg[ci_reg];
                mat_b = sr_reg[mat_idx(cj_reg, ci_reg)];
            end
            M_RSR:
            begin
                mat_a = r_reg[mat_idx(ci_reg, ck_reg)];
                mat_b = sr_reg[mat_idx(ck_reg, cj_reg)];
            end
            M_MM:
            begin
                mat_a = rsr_reg[mat_idx(ci_reg, ck_reg)];
                mat_b = ssr_reg[mat_idx(ck_reg, cj_reg)];
            end
            default:
            begin
                mat_a = m_reg[mat_idx(ci_reg, ck_reg)];
                mat_b = ctr_reg[ck_reg];
            end
        endcase
    end

    assign mul_a   = (state_reg == B_ROD) ? rod_a : mat_a;
    assign mul_b   = (state_reg == B_ROD) ? rod_b : mat_b;
    assign res     = fx_rnd(prod_reg);
    assign acc_new = fx_add((ck_reg == 2'd0) ? 32'sd0 : acc_reg, res);
    assign klast   = (mat_reg == M_SSR) ? 2'd0 : 2'd2;
    assign jlast   = (mat_reg == M_C2) ? 2'd0 : 2'd2;
    assign k_end   = (ck_reg == klast);
    assign j_end   = (cj_reg == jlast);
    assign i_end   = (ci_reg == 2'd2);
    assign tc      = fx_add(trn_reg[ci_reg], ctr_reg[ci_reg]);

    // rotation matrix assembly
    always_comb
    begin
        e[0] = fx_sub(fx_sub(FX_ONE, tmp_reg[2]), tmp_reg[1]);
        e[1] = fx_sub(tmp_reg[3], tmp_reg[8]);
        e[2] = fx_add(tmp_reg[7], tmp_reg[5]);
        e[3] = fx_add(tmp_reg[8], tmp_reg[3]);
        e[4] = fx_sub(fx_sub(FX_ONE, tmp_reg[2]), tmp_reg[0]);
        e[5] = fx_sub(tmp_reg[4], tmp_reg[6]);
        e[6] = fx_sub(tmp_reg[5], tmp_reg[7]);
        e[7] = fx_add(tmp_reg[6], tmp_reg[4]);
        e[8] = fx_sub(fx_sub(FX_ONE, tmp_reg[1]), tmp_reg[0]);
    end

    // sequencer and parameter store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            mat_reg     <= M_SSR;
            ph_reg      <= 1'b0;
            rsel_reg    <= 1'b0;
            u_reg       <= '0;
            ci_reg      <= '0;
            cj_reg      <= '0;
            ck_reg      <= '0;
            out_row_reg <= '0;
            rot_a_reg   <= '0;
            sor_a_reg   <= '0;
            for (int n = 0; n < 3; n++)
            begin
                rot_reg[n] <= '0;
                ctr_reg[n] <= '0;
                sor_reg[n] <= '0;
                scl_reg[n] <= FX_ONE;
                trn_reg[n] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (avail)
                    begin
                        if (item.store)
                        begin
                            case (item.func)
                                FUNC_ROT:
                                begin
                                    rot_reg[0] <= item.x;
                                    rot_reg[1] <= item.y;
                                    rot_reg[2] <= item.z;
                                    rot_a_reg  <= item.ang;
                                end
                                FUNC_CTR:
                                begin
                                    ctr_reg[0] <= item.x;
                                    ctr_reg[1] <= item.y;
                                    ctr_reg[2] <= item.z;
                                end
                                FUNC_SOR:
                                begin
                                    sor_reg[0] <= item.x;
                                    sor_reg[1] <= item.y;
                                    sor_reg[2] <= item.z;
                                    sor_a_reg  <= item.ang;
                                end
                                FUNC_SCALE:
                                begin
                                    scl_reg[0] <= item.x;
                                    scl_reg[1] <= item.y;
                                    scl_reg[2] <= item.z;
                                end
                                FUNC_TRN:
                                begin
                                    trn_reg[0] <= item.x;
                                    trn_reg[1] <= item.y;
                                    trn_reg[2] <= item.z;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        if (item.go)
                        begin
                            rsel_reg  <= 1'b0;
                            state_reg <= B_SC_START;
                        end
                    end
                end
                B_SC_START:
                    state_reg <= B_SC_WAIT;
                B_SC_WAIT:
                begin
                    if (sc_done)
                    begin
                        u_reg     <= '0;
                        ph_reg    <= 1'b0;
                        state_reg <= B_ROD;
                    end
                end
                B_ROD:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                    begin
                        if (u_reg == 4'd14)
                            state_reg <= B_ROD_OUT;
                        else
                            u_reg <= u_reg + 1'b1;
                    end
                end
                B_ROD_OUT:
                begin
                    if (!rsel_reg)
                    begin
                        rsel_reg  <= 1'b1;
                        state_reg <= B_SC_START;
                    end
                    else
                    begin
                        mat_reg   <= M_SSR;
                        ci_reg    <= '0;
                        cj_reg    <= '0;
                        ck_reg    <= '0;
                        ph_reg    <= 1'b0;
                        state_reg <= B_MAT;
                    end
                end
                B_MAT:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                    begin
                        if (!k_end)
                            ck_reg <= ck_reg + 1'b1;
                        else
                        begin
                            ck_reg <= '0;
                            if (!j_end)
                                cj_reg <= cj_reg + 1'b1;
                            else
                            begin
                                cj_reg <= '0;
                                if (!i_end)
                                    ci_reg <= ci_reg + 1'b1;
                                else
                                begin
                                    ci_reg <= '0;
                                    case (mat_reg)
                                        M_SSR:   mat_reg <= M_RSR;
                                        M_RSR:   mat_reg <= M_MM;
                                        M_MM:    mat_reg <= M_C2;
                                        default:
                                        begin
                                            out_row_reg <= '0;
                                            state_reg   <= B_HOLD;
                                        end
                                    endcase
                                end
                            end
                        end
                    end
                end
                B_HOLD:
                begin
                    if (pop)
                    begin
                        out_row_reg <= out_row_reg + 1'b1;
                        if (out_row_reg == 2'd2)
                            state_reg <= B_IDLE;
                    end
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

    // shared multiplier and result registers
    always_ff @(posedge clk)
    begin
        if (!ph_reg && (state_reg == B_ROD || state_reg == B_MAT))
            prod_reg <= mul_a * mul_b;
        if (state_reg == B_SC_WAIT && sc_done)
        begin
            sth_reg <= sc_sin;
            vth_reg <= fx_sub(FX_ONE, sc_cos);
        end
        if (state_reg == B_ROD && ph_reg)
        begin
            hold_reg <= res;
            if (tmp_we)
                tmp_reg[tmp_idx] <= res;
        end
        if (state_reg == B_ROD_OUT)
        begin
            for (int n = 0; n < 9; n++)
            begin
                if (rsel_reg)
                    sr_reg[n] <= e[n];
                else
                    r_reg[n] <= e[n];
            end
        end
        if (state_reg == B_MAT && ph_reg)
        begin
            acc_reg <= acc_new;
            if (k_end)
            begin
                case (mat_reg)
                    M_SSR:   ssr_reg[mat_idx(ci_reg, cj_reg)] <= acc_new;
                    M_RSR:   rsr_reg[mat_idx(ci_reg, cj_reg)] <= acc_new;
                    M_MM:    m_reg[mat_idx(ci_reg, cj_reg)]   <= acc_new;
                    default: c3_reg[ci_reg] <= fx_add(fx_sub(32'sd0, acc_new), tc);
                endcase
            end
        end
        // advance rows on each result transaction
        if (state_reg == B_HOLD && pop)
        begin
            for (int n = 0; n < 6; n++)
                m_reg[n] <= m_reg[n + 3];
            c3_reg[0] <= c3_reg[1];
            c3_reg[1] <= c3_reg[2];
        end
    end

endmodule
`default_nettype wire

### design/scene_transform_matrix.sv
// load transactions pass through the input queue before they update the parameter store
// a compute transaction makes two cordic runs and two rodrigues builds,
// then 72 two-phase steps on the one multiplier
// the three rows then wait for pop; the input queue holds two transactions meanwhile
// reset clears the queue and sequencers; the store resets to zero with scale at 1.0
`default_nettype none
module scene_transform_matrix (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [2:0]         func,
    input  wire logic signed [31:0] comp_x,
    input  wire logic signed [31:0] comp_y,
    input  wire logic signed [31:0] comp_z,
    input  wire logic signed [31:0] angle,
    input  wire logic               go,
    output logic                    empty,
    input  wire logic               pop,
    output logic [1:0]              row,
    output logic signed [31:0]      col0,
    output logic signed [31:0]      col1,
    output logic signed [31:0]      col2,
    output logic signed [31:0]      col3,
    output logic                    last_row
);
    import stfm_pkg::*;

    stfm_item_t item;
    logic       avail, deq;

    // front: accept and classify
    stfm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .func   (func),
        .comp_x (comp_x),
        .comp_y (comp_y),
        .comp_z (comp_z),
        .angle  (angle),
        .go     (go),
        .deq    (deq),
        .avail  (avail),
        .item   (item)
    );

    // back: store, compute, emit rows
    stfm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .avail    (avail),
        .item     (item),
        .deq      (deq),
        .empty    (empty),
        .pop      (pop),
        .row      (row),
        .col0     (col0),
        .col1     (col1),
        .col2     (col2),
        .col3     (col3),
        .last_row (last_row)
    );

endmodule
`default_nettype wire

### test/stfm_checker.sv
`timescale 1ns / 1ps
module stfm_checker
    import stfm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic               full,
    input  wire logic [2:0]         func,
    input  wire logic signed [31:0] comp_x,
    input  wire logic signed [31:0] comp_y,
    input  wire logic signed [31:0] comp_z,
    input  wire logic signed [31:0] angle,
    input  wire logic               go,
    input  wire logic               empty,
    input  wire logic               pop,
    input  wire logic [1:0]         row,
    input  wire logic signed [31:0] col0,
    input  wire logic signed [31:0] col1,
    input  wire logic signed [31:0] col2,
    input  wire logic signed [31:0] col3,
    input  wire logic               last_row,
    output int                      fail_count,
    output int                      rows_pending
);

    typedef struct {
        logic [1:0]         r;
        logic signed [31:0] c [4];
        logic               lr;
    } row_t;

    typedef longint mat3_t [3][3];

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_INV    = 64'sd652032874;
    localparam int     N_ITERS     = (CORDIC_ITERS < 30) ? CORDIC_ITERS : 30;

    longint atan_lut [30] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 7, 3, 1};

    longint params [20];
    row_t   expected_rows [$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clamp32((a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    endfunction

    function automatic longint qadd(longint a, longint b);
        return clamp32(a + b);
    endfunction

    // cordic sine and cosine with range folding
    task automatic sin_cos(input longint ang, output longint s, output longint c);
        longint z, x, y, nx;
        bit     flip;
        z = ang * (64'sd1 <<< (30 - FRAC_BITS));
        x = GAIN_INV;
        y = 0;
        flip = 0;
        z = z % TWO_PI_Q30;
        if (z > PI_Q30)
            z -= TWO_PI_Q30;
        if (z < -PI_Q30)
            z += TWO_PI_Q30;
        if (z > HALF_PI_Q30)
        begin
            z -= PI_Q30;
            flip = 1;
        end
        else if (z < -HALF_PI_Q30)
        begin
            z += PI_Q30;
            flip = 1;
        end
        for (int i = 0; i < N_ITERS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_lut[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_lut[i];
            end
            x = nx;
        end
        x = (x + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        y = (y + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = clamp32(y);
        c = clamp32(x);
    endtask

    // axis-angle rotation from the four words at base
    task automatic axis_rotation(input int base, output mat3_t m);
        longint one, s, c, v, ax, ay, az, xx, yy, zz, xy, yz, zx;
        one = 64'sd1 <<< FRAC_BITS;
        sin_cos(params[base+3], s, c);
        v = qadd(one, -c);
        ax = params[base];
        ay = params[base+1];
        az = params[base+2];
        xx = qmul(qmul(ax, ax), v);
        yy = qmul(qmul(ay, ay), v);
        zz = qmul(qmul(az, az), v);
        xy = qmul(qmul(ax, ay), v);
        yz = qmul(qmul(ay, az), v);
        zx = qmul(qmul(az, ax), v);
        ax = qmul(ax, s);
        ay = qmul(ay, s);
        az = qmul(az, s);
        m[0][0] = qadd(qadd(one, -zz), -yy);
        m[0][1] = qadd(-az, xy);
        m[0][2] = qadd(ay, zx);
        m[1][0] = qadd(az, xy);
        m[1][1] = qadd(qadd(one, -zz), -xx);
        m[1][2] = qadd(-ax, yz);
        m[2][0] = qadd(-ay, zx);
        m[2][1] = qadd(ax, yz);
        m[2][2] = qadd(qadd(one, -yy), -xx);
    endtask

    task automatic mat_mul(input mat3_t a, input mat3_t b, output mat3_t p);
        longint acc;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc = qadd(acc, qmul(a[i][k], b[k][j]));
                p[i][j] = acc;
            end
    endtask

    // store the vector and, on go, queue the three matrix rows
    task automatic apply_transaction(input logic [2:0] f, input longint vx, input longint vy,
                                     input longint vz, input longint va, input logic g);
        mat3_t r, sr, ssr, rsr, m;
        longint acc, tcol;
        row_t e;
        if (f <= FUNC_TRN)
        begin
            params[f*4]   = vx;
            params[f*4+1] = vy;
            params[f*4+2] = vz;
            params[f*4+3] = va;
        end
        if (g)
        begin
            axis_rotation(0, r);
            axis_rotation(8, sr);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    ssr[i][j] = qmul(params[12+i], sr[j][i]);
            mat_mul(r, sr, rsr);
            mat_mul(rsr, ssr, m);
            for (int i = 0; i < 3; i++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc = qadd(acc, qmul(m[i][k], params[4+k]));
                tcol = qadd(qadd(0, -acc), qadd(params[16+i], params[4+i]));
                e.r = 2'(i);
                for (int j = 0; j < 3; j++)
                    e.c[j] = 32'(m[i][j]);
                e.c[3] = 32'(tcol);
                e.lr = (i == 2);
                expected_rows.push_back(e);
            end
        end
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    assign rows_pending = expected_rows.size();

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        row_t e;
        logic signed [31:0] got [4];
        if (!rst_n)
        begin
            foreach (params[i])
                params[i] = 0;
            for (int i = 12; i < 15; i++)
                params[i] = 64'sd1 <<< FRAC_BITS;
            expected_rows.delete();
            fail_count = 0;
        end
        else
        begin
            if (!empty && pop)
            begin
                if (expected_rows.size() == 0)
                begin
                    report("unexpected row transaction", row, -1);
                end
                else
                begin
                    e = expected_rows.pop_front();
                    got = '{col0, col1, col2, col3};
                    if (row !== e.r)
                        report("row", row, e.r);
                    for (int j = 0; j < 4; j++)
                        if (got[j] !== e.c[j])
                            report($sformatf("row %0d col%0d", e.r, j), got[j], e.c[j]);
                    if (last_row !== e.lr)
                        report("last_row", last_row, e.lr);
                end
            end
            if (push && !full)
                apply_transaction(func, comp_x, comp_y, comp_z, angle, go);
        end
    end

endmodule

### test/tb_scene_transform_matrix.sv
`timescale 1ns / 1ps
module tb_scene_transform_matrix;
    import stfm_pkg::*;

    localparam int  N_RANDOM  = 480;
    localparam longint CYCLE_LIMIT = 3000000;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               push = 0;
    logic               full;
    logic [2:0]         func = 0;
    logic signed [31:0] comp_x = 0;
    logic signed [31:0] comp_y = 0;
    logic signed [31:0] comp_z = 0;
    logic signed [31:0] angle = 0;
    logic               go = 0;
    logic               empty;
    logic               pop = 0;
    logic [1:0]         row;
    logic signed [31:0] col0, col1, col2, col3;
    logic               last_row;
    int                 fail_count;
    int                 rows_pending;
    longint             cycles = 0;

    always #1 clk = ~clk;

    scene_transform_matrix u_top (.*);

    stfm_checker u_chk (.*);

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // q16.16 component: mostly modest, sometimes extreme or fully random
    function automatic logic signed [31:0] rand_comp();
        int p;
        p = $urandom_range(99);
        if (p < 60)
            return $signed($urandom_range(196608)) - 98304;
        if (p < 75)
            return $urandom();
        if (p < 82)
            return 32'sh7fffffff;
        if (p < 89)
            return 32'sh80000000;
        return $signed($urandom_range(131072)) - 65536;
    endfunction

    // push stays high across back-to-back transactions
    task automatic send(input logic [2:0] f, input logic signed [31:0] x,
                        input logic signed [31:0] y, input logic signed [31:0] z,
                        input logic signed [31:0] a, input logic g);
        int n;
        n = gap_len();
        if (n > 0)
        begin
            push <= 0;
            repeat (n) @(posedge clk);
        end
        push   <= 1;
        func   <= f;
        comp_x <= x;
        comp_y <= y;
        comp_z <= z;
        angle  <= a;
        go     <= g;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // pop side stalls at random
    always @(posedge clk)
    begin
        if (rst_n)
            pop <= ($urandom_range(99) < 8) ? 0 : ($urandom_range(99) < 60);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int sent;
        logic [2:0] f;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset state, extremes, unused codes, go clear
        send(FUNC_ROT, 0, 0, 0, 0, 1);
        send(FUNC_ROT, 32'sh10000, 0, 0, 32'sh1921f, 0);
        send(FUNC_CTR, 32'sh10000, 32'sh20000, -32'sh30000, 0, 0);
        send(FUNC_SOR, 0, 32'sh10000, 0, 32'sh3243f, 0);
        send(FUNC_SCALE, 32'sh20000, 32'sh8000, -32'sh10000, 0, 0);
        send(FUNC_TRN, 32'sh50000, -32'sh50000, 32'sh1, 0, 1);
        send(FUNC_ROT, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1);
        send(FUNC_SOR, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1);
        send(FUNC_CTR, 32'sh7fffffff, 32'sh80000000, -1, 32'sh7fffffff, 1);
        send(FUNC_SCALE, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, -1, 1);
        send(FUNC_TRN, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 1);
        send(3'd5, 1, 2, 3, 4, 1);
        send(3'd6, -1, -1, -1, -1, 0);
        send(3'd7, 32'sh7fffffff, 0, 0, 32'sh7fffffff, 1);
        send(FUNC_ROT, 32'sh12345, -32'sh6789, 32'sh4000, -32'sh4b65f, 1);
        send(FUNC_SOR, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh6487e, 1);

        // random: mostly full five-vector loads ending in go
        sent = 0;
        while (sent < N_RANDOM)
        begin
            if ($urandom_range(99) < 75)
            begin
                for (int v = 0; v < 5; v++)
                begin
                    send(3'(v), rand_comp(), rand_comp(), rand_comp(), rand_comp(), v == 4);
                    sent++;
                end
            end
            else
            begin
                f = $urandom_range(99) < 85 ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
                send(f, rand_comp(), rand_comp(), rand_comp(), $urandom(),
                     $urandom_range(99) < 30);
                sent++;
            end
        end
        push <= 0;

        while (rows_pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0 && rows_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
